[sv/sld_pkg.sv]
`default_nettype none

package sld_pkg;

    localparam int STORE_DEPTH  = 256;
    localparam int STORE_AW     = 8;
    localparam int BITS_PER_PIX = 24;
    localparam int TAIL_PERIODS = 2;

    localparam logic [11:0] PERIOD_RST    = 12'd90;
    localparam logic [11:0] HIGH_ZERO_RST = 12'd29;
    localparam logic [11:0] HIGH_ONE_RST  = 12'd58;
    localparam logic [15:0] GAP_RST       = 16'd4006;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_CLEAR = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_TAIL = 2'd2,
        PH_GAP  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        REG_PERIOD    = 2'd0,
        REG_HIGH_ZERO = 2'd1,
        REG_HIGH_ONE  = 2'd2,
        REG_GAP       = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_ADDR = 2'd1,
        S_EXEC = 2'd2
    } t_state;

    typedef struct packed {
        logic [11:0] period_ticks;
        logic [11:0] high_zero;
        logic [11:0] high_one;
        logic [15:0] reset_ticks;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mem_wr;
        logic mem_rd;
        logic clr;
        logic step;
        logic flush;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        t_op op;
    } t_dp_status;

endpackage

`default_nettype wire

[sv/sld_cfg.sv]
`default_nettype none

module sld_cfg
    import sld_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_ticks <= PERIOD_RST;
            r_cfg.high_zero    <= HIGH_ZERO_RST;
            r_cfg.high_one     <= HIGH_ONE_RST;
            r_cfg.reset_ticks  <= GAP_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_PERIOD:    r_cfg.period_ticks <= pwdata[11:0];
                REG_HIGH_ZERO: r_cfg.high_zero    <= pwdata[11:0];
                REG_HIGH_ONE:  r_cfg.high_one     <= pwdata[11:0];
                REG_GAP:       r_cfg.reset_ticks  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PERIOD:    prdata = {20'd0, r_cfg.period_ticks};
            REG_HIGH_ZERO: prdata = {20'd0, r_cfg.high_zero};
            REG_HIGH_ONE:  prdata = {20'd0, r_cfg.high_one};
            REG_GAP:       prdata = {16'd0, r_cfg.reset_ticks};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[sv/sld_ctrl.sv]
`default_nettype none

module sld_ctrl
    import sld_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_dp_status i_status,
    output logic            o_busy,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ADDR;
                end
            end
            S_ADDR: begin
                // Store access: a pixel write, a fetch for the tick, or a clear.
                o_cmd.mem_wr = (i_status.op == OP_PIXEL);
                o_cmd.mem_rd = (i_status.op == OP_TICK);
                o_cmd.clr    = (i_status.op == OP_CLEAR);
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.step  = (i_status.op == OP_TICK);
                o_cmd.flush = (i_status.op == OP_FLUSH);
                o_cmd.emit  = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_busy)
        else $error("controller not busy after taking a word");

    a_exec_follows_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR) |=> o_cmd.emit)
        else $error("store access not followed by execute");

    a_store_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.mem_wr, o_cmd.mem_rd, o_cmd.clr, o_cmd.step, o_cmd.flush}))
        else $error("more than one datapath operation at once");

endmodule

`default_nettype wire

[sv/sld_dp.sv]
`default_nettype none

module sld_dp
    import sld_pkg::*;
#(
    parameter int COLS = 16,
    parameter int ROWS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    input  wire t_cfg       i_cfg,
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_col_x,
    input  wire logic [7:0] i_row_y,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    output t_dp_status      o_status,
    output logic            o_valid,
    output logic            o_line_level,
    output logic            o_ready_res
);

    localparam int PIX_TOTAL  = COLS * ROWS;
    localparam int SEND_COUNT = (PIX_TOTAL < STORE_DEPTH) ? PIX_TOTAL : STORE_DEPTH;

    // Captured item.
    t_op         r_op;
    logic [7:0]  r_x;
    logic [7:0]  r_y;
    logic [7:0]  r_r;
    logic [7:0]  r_g;
    logic [7:0]  r_b;

    // Frame store and its valid bits; an entry that is not valid reads as dark.
    logic [23:0]            mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_vld;
    logic [23:0]            r_rd_data;
    logic                   r_rd_vld;

    // Transmitter state.
    t_phase      r_phase;
    logic [8:0]  r_led;
    logic [4:0]  r_bit;
    logic [15:0] r_tick;
    logic        r_ready;
    logic        r_line;
    logic        r_out_vld;

    t_phase      n_phase;
    logic [8:0]  n_led;
    logic [4:0]  n_bit;
    logic [15:0] n_tick;
    logic        n_ready;
    logic        n_line;

    logic [16:0] w_row_ofs;
    logic [16:0] w_idx;
    logic        w_wr_ok;
    logic [11:0] w_per;
    logic [15:0] w_gap;
    logic [23:0] w_word;
    logic        w_bit;
    logic [11:0] w_hi_raw;
    logic [11:0] w_hi;
    logic        w_lvl;
    logic [16:0] w_tick_inc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_op'(i_op);
            r_x  <= i_col_x;
            r_y  <= i_row_y;
            r_r  <= i_red;
            r_g  <= i_green;
            r_b  <= i_blue;
        end
    end

    assign o_status.op = r_op;

    // Serpentine wiring: odd columns run from the bottom row upward.
    assign w_row_ofs = r_x[0] ? (17'(ROWS - 1) - 17'(r_y)) : 17'(r_y);
    assign w_idx     = 17'(r_x) * 17'(ROWS) + w_row_ofs;
    assign w_wr_ok   = ({1'b0, r_x} < 9'(COLS)) && ({1'b0, r_y} < 9'(ROWS))
                       && (w_idx < 17'(STORE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && w_wr_ok) begin
            mem[w_idx[STORE_AW-1:0]] <= {r_g, r_r, r_b};
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= mem[r_led[STORE_AW-1:0]];
            r_rd_vld  <= r_vld[r_led[STORE_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_vld <= '0;
        end else if (i_cmd.mem_wr && w_wr_ok) begin
            r_vld[w_idx[STORE_AW-1:0]] <= 1'b1;
        end
    end

    assign w_per      = (i_cfg.period_ticks == 12'd0) ? 12'd1 : i_cfg.period_ticks;
    assign w_gap      = (i_cfg.reset_ticks == 16'd0) ? 16'd1 : i_cfg.reset_ticks;
    assign w_word     = r_rd_vld ? r_rd_data : 24'd0;
    assign w_bit      = w_word[5'(BITS_PER_PIX - 1) - r_bit];
    assign w_hi_raw   = w_bit ? i_cfg.high_one : i_cfg.high_zero;
    assign w_hi       = (w_hi_raw > w_per) ? w_per : w_hi_raw;
    assign w_lvl      = (r_tick < {4'd0, w_hi});
    assign w_tick_inc = {1'b0, r_tick} + 17'd1;

    always_comb begin
        n_phase = r_phase;
        n_led   = r_led;
        n_bit   = r_bit;
        n_tick  = r_tick;
        n_ready = r_ready;
        n_line  = r_line;
        if (i_cmd.step) begin
            n_line = 1'b0;
            case (r_phase)
                PH_DATA: begin
                    n_line = w_lvl;
                    if (w_tick_inc >= {5'd0, w_per}) begin
                        n_tick = 16'd0;
                        if (r_bit >= 5'(BITS_PER_PIX - 1)) begin
                            n_bit = 5'd0;
                            if (r_led >= 9'(SEND_COUNT - 1)) begin
                                n_led   = 9'd0;
                                n_phase = PH_TAIL;
                            end else begin
                                n_led = r_led + 9'd1;
                            end
                        end else begin
                            n_bit = r_bit + 5'd1;
                        end
                    end else begin
                        n_tick = w_tick_inc[15:0];
                    end
                end
                PH_TAIL: begin
                    if (w_tick_inc >= {5'd0, w_per}) begin
                        n_tick = 16'd0;
                        if (r_bit >= 5'(TAIL_PERIODS - 1)) begin
                            n_bit   = 5'd0;
                            n_phase = PH_GAP;
                        end else begin
                            n_bit = r_bit + 5'd1;
                        end
                    end else begin
                        n_tick = w_tick_inc[15:0];
                    end
                end
                PH_GAP: begin
                    if (w_tick_inc >= {1'b0, w_gap}) begin
                        n_tick  = 16'd0;
                        n_phase = PH_IDLE;
                        n_ready = 1'b1;
                    end else begin
                        n_tick = w_tick_inc[15:0];
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.flush && r_ready) begin
            n_ready = 1'b0;
            n_phase = PH_DATA;
            n_led   = 9'd0;
            n_bit   = 5'd0;
            n_tick  = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_GAP;
            r_led     <= 9'd0;
            r_bit     <= 5'd0;
            r_tick    <= 16'd0;
            r_ready   <= 1'b0;
            r_line    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_led     <= n_led;
            r_bit     <= n_bit;
            r_tick    <= n_tick;
            r_ready   <= n_ready;
            r_line    <= n_line;
            r_out_vld <= i_cmd.emit;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_line_level = r_line;
    assign o_ready_res  = r_ready;

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_phase == PH_IDLE))
        else $error("ready set outside the idle phase");

    a_bit_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_bit < 5'(BITS_PER_PIX)))
        else $error("bit counter beyond the pixel word");

    a_ready_falls_on_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_ready)) |-> (r_phase == PH_DATA && r_led == 9'd0))
        else $error("ready dropped without starting a frame");

    a_line_low_off_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_cmd.step) && $past(r_phase) != PH_DATA) |-> !r_line)
        else $error("line driven high outside the data phase");

endmodule

`default_nettype wire

[sv/serial_led_frame_driver.sv]
`default_nettype none

// Serial LED frame driver for a serpentine-wired COLS x ROWS matrix.
// Commands enter on start while busy is low: tick, pixel write, clear frame
// and flush frame, with the pixel fields on their own ports. Every command
// yields one result word on o_line_level and o_ready_res, marked by o_valid
// for a single cycle; the receiver cannot stall it.
// A command passes through capture, frame store access (one write or
// one registered read port), and execute. o_valid rises in the cycle after
// execute, which is also the first cycle a new command may be taken, so the
// block takes no new command before the last one is through.
// Only tick commands advance the waveform: each is one tick of the line. A
// flush is honored only while o_ready_res is high; the frame is then sent
// MSB first, GRB, followed by two low bit periods and the latch gap.
// Timing registers sit at APB byte offsets 0, 4, 8 and 12; the user must
// write them only with no command in flight, which is not enforced. Reset
// loads defaults, darkens the whole store at once, starts in the latch gap.
module serial_led_frame_driver
    import sld_pkg::*;
#(
    parameter int COLS = 16,
    parameter int ROWS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_col_x,
    input  wire logic [7:0]  i_row_y,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    output logic             o_valid,
    output logic             o_line_level,
    output logic             o_ready_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg       w_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    sld_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sld_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    sld_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg        (w_cfg),
        .i_op         (i_cmd),
        .i_col_x      (i_col_x),
        .i_row_y      (i_row_y),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_status     (w_status),
        .o_valid      (o_valid),
        .o_line_level (o_line_level),
        .o_ready_res  (o_ready_res)
    );

endmodule

`default_nettype wire
